>>> rtl/core/lps_pkg.sv
package lps_pkg;

    localparam int COORD_WIDTH_DEF = 10;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic dir_x_negative;
        logic dir_y_negative;
        logic major_is_y;
        logic axis_aligned;
    } t_line_flags;

endpackage

>>> rtl/core/lps_if.sv
interface lps_cmd_if
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lps_pix_if
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic                   last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> rtl/core/lps_advance.sv
module lps_advance
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic [COORD_WIDTH-1:0] i_cursor_x,
    input  logic [COORD_WIDTH-1:0] i_cursor_y,
    input  logic [COORD_WIDTH-1:0] i_target_x,
    input  logic [COORD_WIDTH-1:0] i_target_y,
    input  logic [COORD_WIDTH-1:0] i_minor_delta,
    input  logic [COORD_WIDTH-1:0] i_major_delta,
    input  logic [COORD_WIDTH:0]   i_error_acc,
    input  t_line_flags            i_flags,
    output logic [COORD_WIDTH-1:0] o_cursor_x,
    output logic [COORD_WIDTH-1:0] o_cursor_y,
    output logic [COORD_WIDTH:0]   o_error_acc,
    output logic [COORD_WIDTH-1:0] o_pixel_x,
    output logic [COORD_WIDTH-1:0] o_pixel_y,
    output logic                   o_last_pixel
);

    localparam logic [COORD_WIDTH-1:0] ONE = COORD_WIDTH'(1);

    logic [COORD_WIDTH-1:0] step_x;
    logic [COORD_WIDTH-1:0] step_y;
    logic [COORD_WIDTH:0]   acc_sum;
    logic                   minor_step;
    logic [COORD_WIDTH-1:0] pix_x;
    logic [COORD_WIDTH-1:0] pix_y;

    assign step_x = i_flags.dir_x_negative ? i_cursor_x - ONE : i_cursor_x + ONE;
    assign step_y = i_flags.dir_y_negative ? i_cursor_y - ONE : i_cursor_y + ONE;

    assign acc_sum    = i_error_acc + {1'b0, i_minor_delta};
    assign minor_step = acc_sum > {1'b0, i_major_delta};

    always_comb begin
        pix_x        = i_cursor_x;
        pix_y        = i_cursor_y;
        o_cursor_x   = i_cursor_x;
        o_cursor_y   = i_cursor_y;
        o_error_acc  = i_error_acc;
        o_last_pixel = 1'b0;
        if (i_flags.axis_aligned) begin
            o_last_pixel = (i_cursor_x == i_target_x) && (i_cursor_y == i_target_y);
            if (!o_last_pixel) begin
                if (i_cursor_x != i_target_x) begin
                    o_cursor_x = step_x;
                end
                if (i_cursor_y != i_target_y) begin
                    o_cursor_y = step_y;
                end
            end
        end else begin
            o_error_acc = minor_step ? acc_sum - {1'b0, i_major_delta} : acc_sum;
            if (i_flags.major_is_y) begin
                pix_x        = minor_step ? step_x : i_cursor_x;
                o_cursor_x   = pix_x;
                o_cursor_y   = step_y;
                o_last_pixel = step_y == i_target_y;
            end else begin
                pix_y        = minor_step ? step_y : i_cursor_y;
                o_cursor_y   = pix_y;
                o_cursor_x   = step_x;
                o_last_pixel = step_x == i_target_x;
            end
        end
    end

    assign o_pixel_x = pix_x;
    assign o_pixel_y = pix_y;

endmodule

>>> rtl/core/line_pixel_stepper.sv
// Line pixel stepper: walks the pixels of a straight line, one per advance item.
// Input channel i_cmd carries cmd plus both endpoints. A load item (cmd = 0)
// latches the endpoints and classifies the line; it yields no pixel. An
// advance item (cmd = 1) yields one pixel on o_pix while a line is open, and
// none when idle. Horizontal, vertical and single-point lines give every
// pixel including the end; others step the major axis and stop one short.
// last_pixel marks the final pixel, after which the block is idle again.
// Latency: a pixel appears on o_pix the cycle after its advance item is taken.
// Throughput: one item per cycle while i_cmd.ready is high; each step is an add,
// compare and +/-1 on the cursor registers; the next item uses the new cursor.
// Stall: o_pix is a single output register; i_cmd.ready drops only while that
// register holds a pixel that the receiver has not taken.
// Reset (i_rst_n low, synchronous): idle, no pixel pending, all but pixel data zero.
module line_pixel_stepper
    import lps_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lps_cmd_if.sink   i_cmd,
    lps_pix_if.source o_pix
);

    logic [COORD_WIDTH-1:0] r_cursor_x,    n_cursor_x;
    logic [COORD_WIDTH-1:0] r_cursor_y,    n_cursor_y;
    logic [COORD_WIDTH-1:0] r_target_x;
    logic [COORD_WIDTH-1:0] r_target_y;
    logic [COORD_WIDTH-1:0] r_minor_delta;
    logic [COORD_WIDTH-1:0] r_major_delta;
    logic [COORD_WIDTH:0]   r_error_acc,   n_error_acc;
    t_line_flags            r_flags;
    logic                   r_busy;
    logic                   r_out_valid;
    logic [COORD_WIDTH-1:0] r_pixel_x,     n_pixel_x;
    logic [COORD_WIDTH-1:0] r_pixel_y,     n_pixel_y;
    logic                   r_last_pixel,  n_last_pixel;

    logic                   accept;
    logic                   advance_fire;
    logic [COORD_WIDTH-1:0] adx;
    logic [COORD_WIDTH-1:0] ady;
    logic                   ld_major_is_y;

    assign i_cmd.ready  = !r_out_valid || o_pix.ready;
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign advance_fire = accept && (t_cmd'(i_cmd.cmd) == CMD_ADVANCE) && r_busy;

    assign adx = (i_cmd.end_x >= i_cmd.start_x) ? i_cmd.end_x - i_cmd.start_x
                                                : i_cmd.start_x - i_cmd.end_x;
    assign ady = (i_cmd.end_y >= i_cmd.start_y) ? i_cmd.end_y - i_cmd.start_y
                                                : i_cmd.start_y - i_cmd.end_y;
    assign ld_major_is_y = ady > adx;

    lps_advance #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_advance (
        .i_cursor_x    (r_cursor_x),
        .i_cursor_y    (r_cursor_y),
        .i_target_x    (r_target_x),
        .i_target_y    (r_target_y),
        .i_minor_delta (r_minor_delta),
        .i_major_delta (r_major_delta),
        .i_error_acc   (r_error_acc),
        .i_flags       (r_flags),
        .o_cursor_x    (n_cursor_x),
        .o_cursor_y    (n_cursor_y),
        .o_error_acc   (n_error_acc),
        .o_pixel_x     (n_pixel_x),
        .o_pixel_y     (n_pixel_y),
        .o_last_pixel  (n_last_pixel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_minor_delta <= '0;
            r_major_delta <= '0;
            r_error_acc   <= '0;
            r_flags       <= '0;
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= advance_fire || (r_out_valid && !o_pix.ready);
            if (accept) begin
                if (t_cmd'(i_cmd.cmd) == CMD_LOAD) begin
                    r_cursor_x             <= i_cmd.start_x;
                    r_cursor_y             <= i_cmd.start_y;
                    r_target_x             <= i_cmd.end_x;
                    r_target_y             <= i_cmd.end_y;
                    r_flags.dir_x_negative <= i_cmd.end_x < i_cmd.start_x;
                    r_flags.dir_y_negative <= i_cmd.end_y < i_cmd.start_y;
                    r_flags.axis_aligned   <= (adx == '0) || (ady == '0);
                    r_flags.major_is_y     <= ld_major_is_y;
                    r_major_delta          <= ld_major_is_y ? ady : adx;
                    r_minor_delta          <= ld_major_is_y ? adx : ady;
                    r_error_acc            <= {1'b0, (ld_major_is_y ? adx : ady)};
                    r_busy                 <= 1'b1;
                end else if (r_busy) begin
                    r_cursor_x  <= n_cursor_x;
                    r_cursor_y  <= n_cursor_y;
                    r_error_acc <= n_error_acc;
                    r_busy      <= !n_last_pixel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_fire) begin
            r_pixel_x    <= n_pixel_x;
            r_pixel_y    <= n_pixel_y;
            r_last_pixel <= n_last_pixel;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.pixel_x    = r_pixel_x;
    assign o_pix.pixel_y    = r_pixel_y;
    assign o_pix.last_pixel = r_last_pixel;

endmodule
